// ===== sv/bmv_pkg.sv =====
// ----------------------------------------------------------------------------
// Block mean and variance package
// Field widths, fixed-point format and default parameter values shared by the
// block mean and variance design.
// ----------------------------------------------------------------------------
package bmv_pkg;

    localparam int BMV_SAMPLE_W    = 16;
    localparam int BMV_MEAN_W      = 24;
    localparam int BMV_VAR_W       = 39;
    localparam int BMV_FRAC_BITS   = 8;

    localparam int BMV_BLOCK_LEN   = 9;
    localparam int BMV_SAMPLE_BITS = 16;

    // Numerator bits resolved by each stage of the constant dividers.
    localparam int BMV_DIV_CHUNK   = 16;

    function automatic int bmv_max(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

// ===== sv/bmv_cdiv.sv =====
// ----------------------------------------------------------------------------
// Pipelined divider by a constant
// Long division of an unsigned numerator by a fixed divisor, one 16-bit digit
// per pipeline stage, each digit found by a scaled reciprocal multiplication,
// advancing on the shared enable.
// ----------------------------------------------------------------------------
module bmv_cdiv
    import bmv_pkg::*;
#(
    parameter int NUM_W   = 48,
    parameter int DIVISOR = 18
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    output logic [NUM_W-1:0] o_quo
);

    localparam int CH    = BMV_DIV_CHUNK;
    localparam int NST   = (NUM_W + CH - 1) / CH;
    localparam int PAD_W = NST * CH;
    localparam int LG_D  = $clog2(DIVISOR);
    localparam int RW    = bmv_max(LG_D, 1);
    localparam int VW    = CH + RW;
    localparam int MW    = VW + 1;
    localparam int PW    = VW + MW;
    localparam int SHR   = VW + LG_D;

    // The rounded-up reciprocal gives the exact floor for any VW-bit value.
    localparam logic [MW-1:0] RECIP = MW'(((64'd1 << SHR) + DIVISOR - 1) / DIVISOR);

    logic [RW-1:0]    r_rem [NST-1];
    logic [PAD_W-1:0] r_num [NST-1];
    logic [PAD_W-1:0] r_quo [NST];

    for (genvar g = 0; g < NST; g++) begin : g_stage
        localparam int TOP = PAD_W - 1 - g * CH;

        logic [RW-1:0]    w_rem_in;
        logic [PAD_W-1:0] w_num_in;
        logic [PAD_W-1:0] w_quo_in;
        logic [VW-1:0]    w_v;
        logic [PW-1:0]    w_prod;
        logic [CH-1:0]    w_qc;
        logic [VW-1:0]    w_back;
        logic [RW-1:0]    n_rem;
        logic [PAD_W-1:0] n_quo;

        if (g == 0) begin : g_first
            assign w_rem_in = '0;
            assign w_num_in = PAD_W'(i_num);
            assign w_quo_in = '0;
        end else begin : g_next
            assign w_rem_in = r_rem[g-1];
            assign w_num_in = r_num[g-1];
            assign w_quo_in = r_quo[g-1];
        end

        always_comb begin
            w_v    = {w_rem_in, w_num_in[TOP -: CH]};
            w_prod = PW'(w_v) * PW'(RECIP);
            w_qc   = w_prod[SHR +: CH];
            w_back = w_v - VW'(w_qc) * VW'(DIVISOR);
            n_rem  = w_back[RW-1:0];
            n_quo  = w_quo_in;
            n_quo[TOP -: CH] = w_qc;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[g] <= n_quo;
            end
        end

        if (g < NST - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[g] <= n_rem;
                    r_num[g] <= w_num_in;
                end
            end
        end
    end

    assign o_quo = r_quo[NST-1][NUM_W-1:0];

endmodule

// ===== sv/block_mean_variance_top.sv =====
// ----------------------------------------------------------------------------
// Block mean and variance
// Accumulates signed samples over non-overlapping blocks and reports the block
// mean and the population and sample variances in Q8 fixed point.
// ----------------------------------------------------------------------------
// The block takes one sample per clock cycle. The last sample of each block
// starts one result down a pipeline of three arithmetic stages followed by
// constant dividers that resolve 16 numerator bits per stage; o_valid rises
// when that result reaches the output of the last divider stage. Samples inside
// a block are always taken; only the last sample of a block waits, and only
// while the pipeline is held by an untaken result.
module block_mean_variance_top
    import bmv_pkg::*;
#(
    parameter int BLOCK_LEN   = BMV_BLOCK_LEN,
    parameter int SAMPLE_BITS = BMV_SAMPLE_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [BMV_SAMPLE_W-1:0] i_sample,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [BMV_MEAN_W-1:0] o_mean_q8,
    output logic [BMV_VAR_W-1:0]         o_var_population_q8,
    output logic [BMV_VAR_W-1:0]         o_var_sample_q8
);

    localparam int LOG_N  = $clog2(BLOCK_LEN);
    localparam int CNT_W  = LOG_N;
    localparam int EXT_W  = bmv_max(SAMPLE_BITS, BMV_SAMPLE_W);
    localparam int SQ_W   = 2 * SAMPLE_BITS - 1;
    localparam int SUM_W  = SAMPLE_BITS + LOG_N;
    localparam int SSQ_W  = SQ_W + LOG_N;
    localparam int D_W    = 2 * SAMPLE_BITS - 1 + 2 * LOG_N;
    localparam int SH     = BMV_FRAC_BITS + 1;
    localparam int VN_W   = D_W + SH;
    localparam int KE     = bmv_max(SUM_W + BMV_FRAC_BITS, BMV_MEAN_W);
    localparam int MN_W   = KE + LOG_N + 2;
    localparam int NUM_W  = bmv_max(VN_W, MN_W);
    localparam int DIV_ST = (NUM_W + BMV_DIV_CHUNK - 1) / BMV_DIV_CHUNK;
    localparam int PIPE   = 3 + DIV_ST;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BLOCK_LEN - 1);

    logic [EXT_W-1:0]             w_raw;
    logic signed [SAMPLE_BITS-1:0] w_smp;
    logic signed [2*SAMPLE_BITS-1:0] w_sq_full;
    logic [SQ_W-1:0]              w_sq;
    logic                         w_en;
    logic                         w_acc;
    logic                         w_last;

    logic [CNT_W-1:0]             r_cnt;
    logic signed [SUM_W-1:0]      r_sum;
    logic [SSQ_W-1:0]             r_ssq;
    logic signed [SUM_W-1:0]      n_sum;
    logic [SSQ_W-1:0]             n_ssq;
    logic [PIPE-1:0]              r_vld;

    logic signed [SUM_W-1:0]      r_a_sum;
    logic [SSQ_W-1:0]             r_a_ssq;
    logic signed [2*SUM_W-1:0]    w_sum_sq;
    logic [D_W-1:0]               w_nssq;

    logic signed [SUM_W-1:0]      r_b_sum;
    logic [D_W-1:0]               r_b_sq;
    logic [D_W-1:0]               r_b_nssq;
    logic [D_W-1:0]               w_d;

    logic [NUM_W-1:0]             r_c_mnum;
    logic [NUM_W-1:0]             r_c_pnum;
    logic [NUM_W-1:0]             r_c_snum;
    logic [NUM_W-1:0]             n_c_mnum;
    logic [NUM_W-1:0]             n_c_pnum;
    logic [NUM_W-1:0]             n_c_snum;

    logic [NUM_W-1:0]             w_mquo;
    logic [NUM_W-1:0]             w_pquo;
    logic [NUM_W-1:0]             w_squo;

    assign w_raw     = EXT_W'($unsigned(i_sample));
    assign w_smp     = signed'(w_raw[SAMPLE_BITS-1:0]);
    assign w_sq_full = w_smp * w_smp;
    assign w_sq      = w_sq_full[SQ_W-1:0];

    assign w_en    = !r_vld[PIPE-1] || i_ready;
    assign w_last  = (r_cnt == CNT_LAST);
    assign o_ready = !w_last || w_en;
    assign w_acc   = i_valid && o_ready;

    assign n_sum = r_sum + SUM_W'(w_smp);
    assign n_ssq = r_ssq + SSQ_W'(w_sq);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_sum <= '0;
            r_ssq <= '0;
        end else if (w_acc) begin
            if (w_last) begin
                r_cnt <= '0;
                r_sum <= '0;
                r_ssq <= '0;
            end else begin
                r_cnt <= r_cnt + CNT_W'(1);
                r_sum <= n_sum;
                r_ssq <= n_ssq;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[PIPE-2:0], w_acc && w_last};
        end
    end

    assign w_sum_sq = r_a_sum * r_a_sum;
    assign w_nssq   = D_W'(r_a_ssq) * D_W'(BLOCK_LEN);
    assign w_d      = r_b_nssq - r_b_sq;

    always_comb begin
        n_c_mnum = (NUM_W'(r_b_sum) << SH) + NUM_W'(BLOCK_LEN)
                 + (NUM_W'(2 * BLOCK_LEN) << KE);
        n_c_pnum = (NUM_W'(w_d) << SH) + NUM_W'(BLOCK_LEN * BLOCK_LEN);
        n_c_snum = (NUM_W'(w_d) << SH) + NUM_W'(BLOCK_LEN * (BLOCK_LEN - 1));
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_sum  <= n_sum;
            r_a_ssq  <= n_ssq;
            r_b_sum  <= r_a_sum;
            r_b_sq   <= w_sum_sq[D_W-1:0];
            r_b_nssq <= w_nssq;
            r_c_mnum <= n_c_mnum;
            r_c_pnum <= n_c_pnum;
            r_c_snum <= n_c_snum;
        end
    end

    bmv_cdiv #(
        .NUM_W   (NUM_W),
        .DIVISOR (2 * BLOCK_LEN)
    ) u_mean_div (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_c_mnum),
        .o_quo (w_mquo)
    );

    bmv_cdiv #(
        .NUM_W   (NUM_W),
        .DIVISOR (2 * BLOCK_LEN * BLOCK_LEN)
    ) u_pop_div (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_c_pnum),
        .o_quo (w_pquo)
    );

    bmv_cdiv #(
        .NUM_W   (NUM_W),
        .DIVISOR (2 * BLOCK_LEN * (BLOCK_LEN - 1))
    ) u_smp_div (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_c_snum),
        .o_quo (w_squo)
    );

    assign o_valid             = r_vld[PIPE-1];
    assign o_mean_q8           = signed'(BMV_MEAN_W'(w_mquo));
    assign o_var_population_q8 = BMV_VAR_W'(w_pquo);
    assign o_var_sample_q8     = BMV_VAR_W'(w_squo);

    // The sample counter never leaves the block range.
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_LAST)
        else $error("sample counter out of range");

    // A block-ending transaction launches a result and clears the accumulators.
    a_block_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_last) |=> (r_vld[0] && r_cnt == '0 && r_sum == '0 && r_ssq == '0))
        else $error("block end did not launch a result or clear state");

    // A mid-block transaction advances the counter by one.
    a_mid_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && !w_last) |=> (r_cnt == $past(r_cnt) + CNT_W'(1)))
        else $error("counter did not advance on a mid-block transaction");

    // The pipeline holds while a result waits.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> $stable(r_vld))
        else $error("result pipeline moved while stalled");

    // Input back-pressure only ever comes from a held result at block end.
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (w_last && o_valid && !i_ready))
        else $error("input stalled without cause");

endmodule

// ===== verif/bmv_result_monitor.sv =====
// ----------------------------------------------------------------------------
// Block mean and variance result monitor
// Watches the sample and result channels of the block mean and variance
// design, predicts the mean and both variances of every completed block, and
// compares each delivered result with the oldest prediction.
// ----------------------------------------------------------------------------
module bmv_result_monitor
    import bmv_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic signed [BMV_SAMPLE_W-1:0] i_sample,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic signed [BMV_MEAN_W-1:0]  i_mean_q8,
    input  logic [BMV_VAR_W-1:0]          i_var_pop_q8,
    input  logic [BMV_VAR_W-1:0]          i_var_smp_q8,
    output int                            o_mismatches,
    output int                            o_outstanding
);

    typedef struct packed {
        logic signed [BMV_MEAN_W-1:0] mean;
        logic [BMV_VAR_W-1:0]         var_pop;
        logic [BMV_VAR_W-1:0]         var_smp;
    } t_block_stats;

    t_block_stats         pending_stats[$];
    t_block_stats         want;
    logic signed [19:0]   blk_sum;
    logic [33:0]          blk_sqsum;
    logic [3:0]           blk_count;
    longint               smp;
    int                   err_count;

    function automatic longint unsigned q8_round_div(input longint unsigned num,
                                                     input longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = num / den;
        rem = num % den;
        return (quo << BMV_FRAC_BITS) + (((rem << (BMV_FRAC_BITS + 1)) + den) / (2 * den));
    endfunction

    function automatic t_block_stats block_stats(input logic signed [19:0] sum,
                                                 input logic [33:0] sqsum);
        longint          n;
        longint          num;
        longint          mean_l;
        longint unsigned abs_sum;
        longint unsigned dvar;
        t_block_stats    r;
        n   = BMV_BLOCK_LEN;
        num = longint'(sum) * (64'sd1 << (BMV_FRAC_BITS + 1)) + n;
        // The mean rounds with ties upward, so the division must floor.
        if (num >= 0) begin
            mean_l = num / (2 * n);
        end else begin
            mean_l = -((-num + 2 * n - 1) / (2 * n));
        end
        abs_sum = (sum < 0) ? longint'(-longint'(sum)) : longint'(sum);
        dvar    = longint'(n) * longint'(sqsum) - abs_sum * abs_sum;
        r.mean    = BMV_MEAN_W'(mean_l);
        r.var_pop = BMV_VAR_W'(q8_round_div(dvar, n * n));
        r.var_smp = BMV_VAR_W'(q8_round_div(dvar, n * (n - 1)));
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pending_stats.delete();
            blk_sum   = '0;
            blk_sqsum = '0;
            blk_count = '0;
            err_count = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (pending_stats.size() == 0) begin
                    $display("%0t: result with nothing expected, got mean %0d var_pop %0d var_smp %0d",
                             $time, i_mean_q8, i_var_pop_q8, i_var_smp_q8);
                    err_count++;
                end else begin
                    want = pending_stats.pop_front();
                    if (i_mean_q8 !== want.mean) begin
                        $display("%0t: mean_q8 mismatch, expected %0d, got %0d",
                                 $time, want.mean, i_mean_q8);
                        err_count++;
                    end
                    if (i_var_pop_q8 !== want.var_pop) begin
                        $display("%0t: var_population_q8 mismatch, expected %0d, got %0d",
                                 $time, want.var_pop, i_var_pop_q8);
                        err_count++;
                    end
                    if (i_var_smp_q8 !== want.var_smp) begin
                        $display("%0t: var_sample_q8 mismatch, expected %0d, got %0d",
                                 $time, want.var_smp, i_var_smp_q8);
                        err_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                smp       = i_sample;
                blk_sum   = blk_sum + 20'(smp);
                blk_sqsum = blk_sqsum + 34'(smp * smp);
                if (blk_count == 4'(BMV_BLOCK_LEN - 1)) begin
                    pending_stats.insert(pending_stats.size(),
                                         block_stats(blk_sum, blk_sqsum));
                    blk_sum   = '0;
                    blk_sqsum = '0;
                    blk_count = '0;
                end else begin
                    blk_count = blk_count + 4'd1;
                end
            end
        end
        o_mismatches  <= err_count;
        o_outstanding <= pending_stats.size();
    end

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// Block mean and variance testbench
// Drives directed and random sample blocks into the block mean and variance
// design with random idle cycles and back pressure, and reports the verdict
// from the result monitor.
// ----------------------------------------------------------------------------
module tb_top;
    import bmv_pkg::*;

    localparam int RANDOM_ITEMS = 600;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_CYCLES  = 600;
    localparam int CALM_FROM    = 250;
    localparam int CALM_TO      = 350;
    localparam int PAUSE_AT     = 420;
    localparam int DRAIN_CYCLES = 60;
    localparam int STALL_LIMIT  = 3000;

    typedef enum int {MIX_FULL, MIX_SMALL, MIX_EXTREME, MIX_FLAT} block_mix_t;

    logic                           i_clk   = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_valid = 1'b0;
    logic                           i_ready = 1'b0;
    logic signed [BMV_SAMPLE_W-1:0] i_sample = '0;
    logic                           o_ready;
    logic                           o_valid;
    logic signed [BMV_MEAN_W-1:0]   o_mean_q8;
    logic [BMV_VAR_W-1:0]           o_var_population_q8;
    logic [BMV_VAR_W-1:0]           o_var_sample_q8;

    int mismatches;
    int outstanding;
    int n_sent = 0;
    int rx_hold_left = 0;
    bit rx_hold_done = 1'b0;
    int stall_cycles = 0;

    always #5 i_clk = ~i_clk;

    block_mean_variance_top dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_sample            (i_sample),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_mean_q8           (o_mean_q8),
        .o_var_population_q8 (o_var_population_q8),
        .o_var_sample_q8     (o_var_sample_q8)
    );

    bmv_result_monitor u_monitor (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_ready    (o_ready),
        .i_sample      (i_sample),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_mean_q8     (o_mean_q8),
        .i_var_pop_q8  (o_var_population_q8),
        .i_var_smp_q8  (o_var_sample_q8),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // The receiver holds off once for a long stretch so that results back up
    // into the block and the sample input stalls.
    always @(posedge i_clk) begin
        if (!rx_hold_done && n_sent >= HOLD_AT) begin
            rx_hold_done = 1'b1;
            rx_hold_left = HOLD_CYCLES;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_ready <= 1'b0;
        end else if (n_sent >= CALM_FROM && n_sent < CALM_TO) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(99) >= 7);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, stall_cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_sample(input logic signed [BMV_SAMPLE_W-1:0] value, input bit calm);
        if (!calm) begin
            while ($urandom_range(99) < 7) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid  <= 1'b1;
        i_sample <= value;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        n_sent <= n_sent + 1;
    endtask

    task automatic wait_results_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    function automatic logic signed [BMV_SAMPLE_W-1:0] pick_sample(input block_mix_t mix,
            input logic signed [BMV_SAMPLE_W-1:0] flat_value);
        case (mix)
            MIX_FULL: begin
                return BMV_SAMPLE_W'($urandom);
            end
            MIX_SMALL: begin
                return BMV_SAMPLE_W'(int'($urandom_range(8)) - 4);
            end
            MIX_EXTREME: begin
                case ($urandom_range(3))
                    0: return 16'sh8000;
                    1: return 16'sh7fff;
                    2: return -16'sd1;
                    default: return 16'sd0;
                endcase
            end
            default: begin
                return flat_value;
            end
        endcase
    endfunction

    initial begin : stimulus
        logic signed [BMV_SAMPLE_W-1:0] odd_block[9];
        block_mix_t                     mix;
        logic signed [BMV_SAMPLE_W-1:0] flat_value;
        int                             pick;
        bit                             calm;

        odd_block = '{-16'sd1, -16'sd5, 16'sd3, 16'sd0, 16'sd1, -16'sd2,
                      16'sh7fff, 16'sh8000, -16'sd7};
        mix        = MIX_FULL;
        flat_value = '0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < BMV_BLOCK_LEN; k++) send_sample(16'sh8000, 1'b0);
        for (int k = 0; k < BMV_BLOCK_LEN; k++) begin
            send_sample((k % 2 == 0) ? 16'sh7fff : 16'sh8000, 1'b0);
        end
        for (int k = 0; k < BMV_BLOCK_LEN; k++) send_sample(odd_block[k], 1'b0);
        wait_results_drained();

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % BMV_BLOCK_LEN == 0) begin
                pick = $urandom_range(99);
                if (pick < 50) begin
                    mix = MIX_FULL;
                end else if (pick < 70) begin
                    mix = MIX_SMALL;
                end else if (pick < 88) begin
                    mix = MIX_EXTREME;
                end else begin
                    mix = MIX_FLAT;
                end
                flat_value = BMV_SAMPLE_W'($urandom);
            end
            if (i == PAUSE_AT) wait_results_drained();
            calm = (i >= CALM_FROM && i < CALM_TO);
            send_sample(pick_sample(mix, flat_value), calm);
        end

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
